// ----- hw/rtl/gls_pkg.sv -----
`default_nettype none

package gls_pkg;

	// Sequencer states of the arithmetic core
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_GCD  = 6'b000010,
		ST_SHL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// Control from the top level to the core
	typedef struct packed {
		logic start;
		logic take;
	} core_ctl_t;

	// Status from the core to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gls_core.sv -----
`default_nettype none

// Iterative core: binary GCD, shift back of the common power of two,
// restoring divide a/g, then shift-and-add multiply (a/g)*b.
module gls_core #(
	parameter int OPERAND_BITS = 31
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  gls_pkg::core_ctl_t           ctl,
	output gls_pkg::core_sts_t           sts,
	input  wire  [OPERAND_BITS-1:0]      first_value,
	input  wire  [OPERAND_BITS-1:0]      second_value,
	output logic [OPERAND_BITS-1:0]      divisor,
	output logic [2*OPERAND_BITS-1:0]    multiple,
	output logic                         input_error
);

	localparam int N  = OPERAND_BITS;
	localparam int CW = $clog2(N);

	gls_pkg::state_t state_q;

	logic [N-1:0]   a_q, b_q;
	logic [N-1:0]   x_q, y_q;
	logic [CW-1:0]  k_q;
	logic [CW-1:0]  cnt_q;
	logic [N-1:0]   rem_q;
	logic [N-1:0]   quo_q;
	logic [2*N-1:0] acc_q;
	logic           err_q;

	// Shared subtract unit
	logic         x_gt;
	logic [N:0]   sub_a, sub_b, sub_res;

	always_comb begin
		x_gt = (x_q > y_q);
		if (state_q == gls_pkg::ST_DIV) begin
			sub_a = {rem_q, quo_q[N-1]};
			sub_b = {1'b0, x_q};
		end else begin
			sub_a = {1'b0, x_gt ? x_q : y_q};
			sub_b = {1'b0, x_gt ? y_q : x_q};
		end
		sub_res = sub_a - sub_b;
	end

	// Multiply step: shift accumulator, add b when the quotient bit is set
	logic [2*N-1:0] mul_next;
	assign mul_next = {acc_q[2*N-2:0], 1'b0} + (quo_q[N-1] ? {{N{1'b0}}, b_q} : '0);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gls_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				gls_pkg::ST_IDLE: begin
					if (ctl.start) begin
						if (first_value == '0 || second_value == '0) begin
							state_q <= gls_pkg::ST_DONE;
						end else begin
							state_q <= gls_pkg::ST_GCD;
						end
					end
				end
				gls_pkg::ST_GCD: begin
					if (x_q == y_q) state_q <= gls_pkg::ST_SHL;
				end
				gls_pkg::ST_SHL: begin
					if (k_q == '0) state_q <= gls_pkg::ST_DIV;
				end
				gls_pkg::ST_DIV: begin
					if (cnt_q == '0) state_q <= gls_pkg::ST_MUL;
				end
				gls_pkg::ST_MUL: begin
					if (cnt_q == '0) state_q <= gls_pkg::ST_DONE;
				end
				gls_pkg::ST_DONE: begin
					if (ctl.take) state_q <= gls_pkg::ST_IDLE;
				end
				default: state_q <= gls_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			gls_pkg::ST_IDLE: begin
				if (ctl.start) begin
					a_q   <= first_value;
					b_q   <= second_value;
					// zero operand: divisor reads as zero
					x_q   <= (first_value == '0 || second_value == '0) ? '0 : first_value;
					y_q   <= second_value;
					k_q   <= '0;
					acc_q <= '0;
					err_q <= (first_value == '0 || second_value == '0);
				end
			end
			gls_pkg::ST_GCD: begin
				if (x_q != y_q) begin
					if (!x_q[0] && !y_q[0]) begin
						// common factor of two, remembered in k
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + CW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_gt) begin
						x_q <= sub_res[N-1:0];
					end else begin
						y_q <= sub_res[N-1:0];
					end
				end
			end
			gls_pkg::ST_SHL: begin
				if (k_q == '0) begin
					rem_q <= '0;
					quo_q <= a_q;
					cnt_q <= CW'(N-1);
				end else begin
					x_q <= x_q << 1;
					k_q <= k_q - CW'(1);
				end
			end
			gls_pkg::ST_DIV: begin
				// restoring step; borrow means the trial failed
				if (sub_res[N]) begin
					rem_q <= sub_a[N-1:0];
					quo_q <= {quo_q[N-2:0], 1'b0};
				end else begin
					rem_q <= sub_res[N-1:0];
					quo_q <= {quo_q[N-2:0], 1'b1};
				end
				if (cnt_q == '0) begin
					cnt_q <= CW'(N-1);
					acc_q <= '0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			gls_pkg::ST_MUL: begin
				acc_q <= mul_next;
				quo_q <= {quo_q[N-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			gls_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign sts.idle    = (state_q == gls_pkg::ST_IDLE);
	assign sts.done    = (state_q == gls_pkg::ST_DONE);
	assign divisor     = x_q;
	assign multiple    = acc_q;
	assign input_error = err_q;

endmodule

`default_nettype wire

// ----- hw/rtl/gcd_lcm_by_subtraction.sv -----
// Sequence: binary GCD, shift back of the common power of two, then
// OPERAND_BITS divide and OPERAND_BITS multiply steps, plus entry, hand-off
// and output register; a zero operand goes from entry straight to done.
// Throughput: one item at a time; the next is taken once the result has
// entered the output register and the core is idle again. Reset (arst_n,
// asynchronous, active low) empties the core and output register.
`default_nettype none

module gcd_lcm_by_subtraction #(
	parameter int OPERAND_BITS = 31
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [OPERAND_BITS-1:0]      first_value,
	input  wire  [OPERAND_BITS-1:0]      second_value,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [OPERAND_BITS-1:0]      divisor,
	output logic [2*OPERAND_BITS-1:0]    multiple,
	output logic                         input_error
);

	gls_pkg::core_ctl_t ctl;
	gls_pkg::core_sts_t sts;

	logic [OPERAND_BITS-1:0]   core_div;
	logic [2*OPERAND_BITS-1:0] core_mul;
	logic                      core_err;

	logic                      out_valid_q;
	logic [OPERAND_BITS-1:0]   divisor_q;
	logic [2*OPERAND_BITS-1:0] multiple_q;
	logic                      error_q;
	logic                      load;

	// Input side: an item enters only when the core is free
	assign in_stall  = !sts.idle;
	assign load      = sts.done && (!out_valid_q || !out_stall);
	assign ctl.start = in_valid && sts.idle;
	assign ctl.take  = load;

	gls_core #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.first_value  (first_value),
		.second_value (second_value),
		.divisor      (core_div),
		.multiple     (core_mul),
		.input_error  (core_err)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			divisor_q  <= core_div;
			multiple_q <= core_mul;
			error_q    <= core_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign divisor     = divisor_q;
	assign multiple    = multiple_q;
	assign input_error = error_q;

endmodule

`default_nettype wire

// ----- test/gcd_lcm_checker.sv -----
`default_nettype none

// Watches both channels, predicts the divisor and multiple for every
// accepted operand pair and compares them with the results in order.
module gcd_lcm_checker #(
	parameter int OPERAND_BITS = 31
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	input  wire                        in_stall,
	input  wire [OPERAND_BITS-1:0]     first_value,
	input  wire [OPERAND_BITS-1:0]     second_value,
	input  wire                        out_valid,
	input  wire                        out_stall,
	input  wire [OPERAND_BITS-1:0]     divisor,
	input  wire [2*OPERAND_BITS-1:0]   multiple,
	input  wire                        input_error,
	output int                         failures,
	output int                         pending
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [OPERAND_BITS-1:0]   divisor;
		logic [2*OPERAND_BITS-1:0] multiple;
		logic                      input_error;
	} answer_t;

	answer_t answers_due[$];
	int      mismatch_count;

	// Divisor by remainder steps (same value as repeated subtraction),
	// multiple as (a / g) * b at full product width
	function automatic answer_t predict_gcd_lcm(input logic [OPERAND_BITS-1:0] a,
			input logic [OPERAND_BITS-1:0] b);
		answer_t                   res;
		logic [OPERAND_BITS-1:0]   x, y, r;
		logic [2*OPERAND_BITS-1:0] cofactor, other;
		res = '0;
		if (a == '0 || b == '0) begin
			res.input_error = 1'b1;
			return res;
		end
		x = a;
		y = b;
		while (y != '0) begin
			r = x % y;
			x = y;
			y = r;
		end
		cofactor = a / x;
		other = b;
		res.divisor = x;
		res.multiple = cofactor * other;
		return res;
	endfunction

	// Compare accepted results, then log the new item's expected answer
	always @(posedge clk or negedge arst_n) begin
		answer_t want, got;
		if (!arst_n) begin
			answers_due.delete();
			mismatch_count = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{divisor, multiple, input_error};
				if (answers_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: divisor %0d multiple %0d error %0b",
							got.divisor, got.multiple, got.input_error);
				end else begin
					want = answers_due.pop_front();
					if (got.divisor != want.divisor || got.multiple != want.multiple
							|| got.input_error != want.input_error) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("mismatch: divisor %0d/%0d multiple %0d/%0d error %0b/%0b (exp/act)",
								want.divisor, got.divisor, want.multiple, got.multiple,
								want.input_error, got.input_error);
					end
				end
			end
			if (in_valid && !in_stall)
				answers_due.push_back(predict_gcd_lcm(first_value, second_value));
			failures <= mismatch_count;
			pending <= answers_due.size();
		end
	end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;

	localparam int          OPERAND_BITS    = 31;
	localparam int unsigned TOP_VALUE       = 32'h7FFF_FFFF;
	localparam int          CYCLE_LIMIT     = 2_000_000;
	localparam int          DRAIN_CYCLES    = 300;
	localparam int          ITEMS_PER_PHASE = 400;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [OPERAND_BITS-1:0]     first_value;
	logic [OPERAND_BITS-1:0]     second_value;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [OPERAND_BITS-1:0]     divisor;
	logic [2*OPERAND_BITS-1:0]   multiple;
	logic                        input_error;

	int failures;
	int pending;
	int cycle_count    = 0;
	int send_idle_pct  = 26;
	int recv_stall_pct = 51;

	gcd_lcm_by_subtraction #(
		.OPERAND_BITS(OPERAND_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_value(first_value),
		.second_value(second_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.divisor(divisor),
		.multiple(multiple),
		.input_error(input_error)
	);

	gcd_lcm_checker #(
		.OPERAND_BITS(OPERAND_BITS)
	) answer_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_value(first_value),
		.second_value(second_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.divisor(divisor),
		.multiple(multiple),
		.input_error(input_error),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gcd_lcm_by_subtraction verification failed");
			$finish;
		end
	end

	// Offer one operand pair, with random idle cycles in front
	task automatic push_operands(input logic [OPERAND_BITS-1:0] a,
			input logic [OPERAND_BITS-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_value <= a;
		second_value <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Pairs with a shared factor (the largest share), plus full-width noise, small values,
	// equal operands, zero operands and values near the top of the range
	task automatic random_pair(output logic [OPERAND_BITS-1:0] a,
			output logic [OPERAND_BITS-1:0] b);
		int unsigned kind, g, x, y;
		kind = $urandom_range(99);
		if (kind < 45) begin
			g = $urandom_range(1, 1 << $urandom_range(16));
			x = $urandom_range(1, TOP_VALUE / g);
			y = $urandom_range(1, TOP_VALUE / g);
			a = OPERAND_BITS'(g * x);
			b = OPERAND_BITS'(g * y);
		end else if (kind < 70) begin
			a = OPERAND_BITS'($urandom);
			b = OPERAND_BITS'($urandom);
		end else if (kind < 85) begin
			a = OPERAND_BITS'($urandom_range(1, 255));
			b = OPERAND_BITS'($urandom_range(1, 255));
		end else if (kind < 90) begin
			a = OPERAND_BITS'($urandom);
			b = a;
		end else if (kind < 95) begin
			a = OPERAND_BITS'($urandom);
			b = OPERAND_BITS'($urandom);
			case ($urandom_range(2))
				0: a = '0;
				1: b = '0;
				default: begin
					a = '0;
					b = '0;
				end
			endcase
		end else begin
			a = OPERAND_BITS'(TOP_VALUE - $urandom_range(15));
			b = OPERAND_BITS'(32'd1 << $urandom_range(OPERAND_BITS - 1));
			if ($urandom_range(1))
				{a, b} = {b, a};
		end
	endtask

	initial begin
		logic [OPERAND_BITS-1:0] a, b;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		first_value <= '0;
		second_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero operands, equal operands, field extremes
		push_operands('0, '0);
		push_operands('0, 31'd5);
		push_operands(31'd5, '0);
		push_operands(OPERAND_BITS'(TOP_VALUE), '0);
		push_operands('0, OPERAND_BITS'(TOP_VALUE));
		push_operands(31'd1, 31'd1);
		push_operands(31'd7, 31'd7);
		push_operands(OPERAND_BITS'(TOP_VALUE), OPERAND_BITS'(TOP_VALUE));
		push_operands(OPERAND_BITS'(TOP_VALUE), 31'd1);
		push_operands(31'd1, OPERAND_BITS'(TOP_VALUE));
		push_operands(OPERAND_BITS'(TOP_VALUE), OPERAND_BITS'(TOP_VALUE - 1));
		push_operands(OPERAND_BITS'(TOP_VALUE - 1), OPERAND_BITS'(TOP_VALUE));
		push_operands(31'h4000_0000, 31'h4000_0000);
		push_operands(31'h4000_0000, 31'd3);
		push_operands(31'h4000_0000, 31'h6000_0000);
		push_operands(31'd1, 31'h4000_0000);
		push_operands(31'd12, 31'd18);
		push_operands(31'd18, 31'd12);
		push_operands(31'd2, 31'd4);
		push_operands(31'h5555_5555, 31'h2AAA_AAAA);
		push_operands(31'd65537, 31'd65521);

		// Random: receiver-heavy stalling, then sender-heavy idling, then none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 26;
					recv_stall_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (ITEMS_PER_PHASE) begin
				random_pair(a, b);
				push_operands(a, b);
			end
		end
		in_valid <= 1'b0;

		// Drain, then allow time for any stray result
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && pending == 0)
			$display("gcd_lcm_by_subtraction verification clean");
		else
			$display("gcd_lcm_by_subtraction verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/gls_pkg.sv
hw/rtl/gls_core.sv
hw/rtl/gcd_lcm_by_subtraction.sv
test/gcd_lcm_checker.sv
test/tb_top.sv
